// ===== design/cbbs_pkg.sv =====
`default_nettype none

package cbbs_pkg;

	localparam int NUM_BEAMS    = 64;
	localparam int NUM_CONTEXTS = 16;

	localparam int BEAM_W  = $clog2(NUM_BEAMS);
	localparam int CTX_W   = $clog2(NUM_CONTEXTS);
	localparam int ADDR_W  = BEAM_W + CTX_W;
	localparam int ENTRIES = NUM_BEAMS * NUM_CONTEXTS;
	localparam int GROUP_W = BEAM_W + 1;

	localparam int COUNT_W  = 16;
	localparam int SUM_W    = 48;
	localparam int MEAN_W   = 56;
	localparam int FRAC_W   = 8;
	localparam int THR_W    = 24;
	localparam int RND_W    = 16;
	localparam int REWARD_W = 32;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 16;

	localparam int DIV_W   = MEAN_W;
	localparam int DVSR_W  = COUNT_W;
	localparam int STEP_W  = $clog2(DIV_W + 1);

	typedef struct packed {
		logic [MEAN_W-1:0]  mean;
		logic [SUM_W-1:0]   sum;
		logic [COUNT_W-1:0] count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DVSR_W-1:0] divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_W-1:0]  quotient;
		logic [DVSR_W-1:0] remainder;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== design/contextual_bandit_beam_selector.sv =====
`default_nettype none

// channel | dir | tdata (low bit up)                                | tuser
// s       | in  | context_index, explore_threshold, random_value,   | func
//         |     | beam_index, reward, zero pad to 88                |
// m       | out | chosen beam, group_size, zero pad to 16           | explored
//
// after reset the table is zeroed one entry a cycle, all 1024 entries, s_tready low
// a select scans the table and decides, then takes the modulo on the shared divider
// when several beams qualify and walks the group whenever a beam qualifies
// an update reads the entry, runs the 56-step serial mean division and writes it back
// a finished select waits in the output register; the next request is taken meanwhile

module contextual_bandit_beam_selector (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// context_index, explore_threshold, random_value, beam_index, reward
	input  wire logic [cbbs_pkg::IN_DATA_W-1:0]    s_tdata,
	// func
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// beam, group_size
	output logic      [cbbs_pkg::OUT_DATA_W-1:0]   m_tdata,
	// explored
	output logic                                   m_tuser
);

	import cbbs_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_MOD,
		ST_PICK,
		ST_OUT,
		ST_UPD_RD,
		ST_UPD_CALC,
		ST_UPD_DIV
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0]   clr_q;
	logic [CTX_W-1:0]    ctx_q;
	logic [THR_W-1:0]    thr_q;
	logic [RND_W-1:0]    rnd_q;
	logic [BEAM_W-1:0]   beam_q;
	logic [REWARD_W-1:0] reward_q;

	logic [BEAM_W:0]     a_q;
	logic                vld_s1;
	logic [BEAM_W-1:0]   beam_s1;
	logic [GROUP_W-1:0]  group_q;
	logic [NUM_BEAMS-1:0] flags_q;
	logic [MEAN_W-1:0]   best_q;
	logic [BEAM_W-1:0]   best_beam_q;
	logic [GROUP_W-1:0]  pick_q;
	logic [GROUP_W-1:0]  seen_q;
	logic [BEAM_W-1:0]   idx_q;
	logic [BEAM_W-1:0]   res_beam_q;
	logic                res_expl_q;
	logic [SUM_W-1:0]    upd_sum_q;
	logic [COUNT_W-1:0]  upd_cnt_q;

	logic [BEAM_W-1:0]   out_beam_q;
	logic [GROUP_W-1:0]  out_group_q;
	logic                out_expl_q;
	logic                m_tvalid_q;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	entry_t              ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	entry_t              ram_rdata;
	logic [ENTRY_W-1:0]  ram_rbits;

	div_req_t            div_req;
	div_rsp_t            div_rsp;

	logic                s_fire;
	logic                out_load;
	logic                under;
	logic [SUM_W:0]      sum_ext;
	logic [SUM_W-1:0]    sum_sat;
	logic [COUNT_W-1:0]  cnt_sat;

	assign s_tready = state_q == ST_IDLE;
	assign s_fire   = s_tvalid && s_tready;
	assign out_load = state_q == ST_OUT && (!m_tvalid_q || m_tready);
	assign ram_rdata = entry_t'(ram_rbits);

	always_comb begin
		under   = {ram_rdata.count, {FRAC_W{1'b0}}} <= thr_q;
		sum_ext = {1'b0, ram_rdata.sum} + (SUM_W + 1)'(reward_q);
		sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
		cnt_sat = (ram_rdata.count == {COUNT_W{1'b1}}) ? ram_rdata.count
			: ram_rdata.count + COUNT_W'(1);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = {a_q[BEAM_W-1:0], ctx_q};
		div_req   = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_SCAN: begin
				ram_re = a_q < (BEAM_W + 1)'(NUM_BEAMS);
			end
			ST_DECIDE: begin
				div_req.start    = group_q > GROUP_W'(1);
				div_req.dividend = {rnd_q, {(DIV_W - RND_W){1'b0}}};
				div_req.divisor  = DVSR_W'(group_q);
				div_req.steps    = STEP_W'(RND_W);
			end
			ST_UPD_RD: begin
				ram_re    = 1'b1;
				ram_raddr = {beam_q, ctx_q};
			end
			ST_UPD_CALC: begin
				div_req.start    = 1'b1;
				div_req.dividend = {sum_sat, {FRAC_W{1'b0}}};
				div_req.divisor  = cnt_sat;
				div_req.steps    = STEP_W'(DIV_W);
			end
			ST_UPD_DIV: begin
				ram_we    = div_rsp.done;
				ram_waddr = {beam_q, ctx_q};
				ram_wdata = '{mean: div_rsp.quotient, sum: upd_sum_q, count: upd_cnt_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			a_q        <= '0;
			vld_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					a_q    <= '0;
					vld_s1 <= 1'b0;
					if (s_fire) begin
						state_q <= s_tuser ? ST_UPD_RD : ST_SCAN;
					end
				end
				ST_SCAN: begin
					vld_s1 <= ram_re;
					if (ram_re) begin
						a_q <= a_q + (BEAM_W + 1)'(1);
					end
					if (vld_s1 && beam_s1 == BEAM_W'(NUM_BEAMS - 1)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (group_q == '0) begin
						state_q <= ST_OUT;
					end else if (group_q == GROUP_W'(1)) begin
						state_q <= ST_PICK;
					end else begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (div_rsp.done) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (flags_q[0] && seen_q == pick_q) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				ST_UPD_RD: begin
					state_q <= ST_UPD_CALC;
				end
				ST_UPD_CALC: begin
					state_q <= ST_UPD_DIV;
				end
				ST_UPD_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request fields and working registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			ctx_q    <= s_tdata[CTX_W-1:0];
			thr_q    <= s_tdata[4 +: THR_W];
			rnd_q    <= s_tdata[28 +: RND_W];
			beam_q   <= s_tdata[44 +: BEAM_W];
			reward_q <= s_tdata[50 +: REWARD_W];
			group_q  <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (ram_re) begin
				beam_s1 <= a_q[BEAM_W-1:0];
			end
			if (vld_s1) begin
				flags_q <= {under, flags_q[NUM_BEAMS-1:1]};
				group_q <= group_q + GROUP_W'(under);
				if (beam_s1 == '0 || ram_rdata.mean > best_q) begin
					best_q      <= ram_rdata.mean;
					best_beam_q <= beam_s1;
				end
			end
		end
		if (state_q == ST_DECIDE) begin
			pick_q     <= '0;
			seen_q     <= '0;
			idx_q      <= '0;
			res_beam_q <= best_beam_q;
			res_expl_q <= group_q != '0;
		end
		if (state_q == ST_MOD && div_rsp.done) begin
			pick_q <= div_rsp.remainder[GROUP_W-1:0];
		end
		if (state_q == ST_PICK) begin
			flags_q <= flags_q >> 1;
			idx_q   <= idx_q + BEAM_W'(1);
			if (flags_q[0]) begin
				seen_q <= seen_q + GROUP_W'(1);
				if (seen_q == pick_q) begin
					res_beam_q <= idx_q;
				end
			end
		end
		if (out_load) begin
			out_beam_q  <= res_beam_q;
			out_group_q <= group_q;
			out_expl_q  <= res_expl_q;
		end
		if (state_q == ST_UPD_CALC) begin
			upd_sum_q <= sum_sat;
			upd_cnt_q <= cnt_sat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - GROUP_W - BEAM_W){1'b0}}, out_group_q, out_beam_q};
	assign m_tuser  = out_expl_q;

	cbbs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ENTRY_W'(ram_wdata)),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rbits)
	);

	cbbs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

endmodule

`default_nettype wire

// ===== design/cbbs_ram.sv =====
`default_nettype none

module cbbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/cbbs_div.sv =====
`default_nettype none

module cbbs_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cbbs_pkg::div_req_t req,
	output cbbs_pkg::div_rsp_t      rsp
);

	import cbbs_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIV_W-1:0]  num_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DVSR_W-1:0] rem_q;
	logic [DVSR_W-1:0] dvsr_q;

	logic [DVSR_W:0]   trial;
	logic              ge;
	logic [DVSR_W-1:0] rem_nxt;

	// one restoring step per cycle
	always_comb begin
		trial   = {rem_q, num_q[DIV_W-1]};
		ge      = trial >= {1'b0, dvsr_q};
		rem_nxt = ge ? DVSR_W'(trial - {1'b0, dvsr_q}) : trial[DVSR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && cnt_q == STEP_W'(1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.dividend;
			dvsr_q <= req.divisor;
			quo_q  <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire
